/* rtl/core/pcsr_pkg.sv */
// shared constants and helpers for the packed csr row decompressor
`timescale 1ns / 1ps
package pcsr_pkg;

    localparam int GROUP_SIZE = 16;
    localparam int GAP_BITS   = 4;
    localparam int COL_W      = 14;
    localparam int ADDR_W     = 25;

    localparam logic [0:0] REG_ROW_STRIDE  = 1'd0;
    localparam logic [0:0] REG_DEST_OFFSET = 1'd1;

    localparam logic [COL_W-1:0] COL_SAT = 14'd8191;

    // exact fp16 to fp32, subnormals normalized by a priority search over 10 bits
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0] e;
        logic [9:0] m;
        logic [9:0] mn;
        logic [7:0] se;
        logic [22:0] sm;
        logic [3:0] s;
        e = h[14:10];
        m = h[9:0];
        se = 8'd0;
        sm = 23'd0;
        s = 4'd0;
        mn = 10'd0;
        if (e == 5'd0) begin
            if (m != 10'd0) begin
                for (int i = 0; i < 10; i++) begin
                    if (m[i])
                        s = 4'(10 - i);
                end
                mn = m << s;
                se = 8'd113 - {4'd0, s};
                sm = {mn, 13'd0};
            end
        end else if (e == 5'd31) begin
            se = 8'd255;
            sm = {m, 13'd0};
            if (m != 10'd0)
                sm[22] = 1'b1;
        end else begin
            se = {3'd0, e} + 8'd112;
            sm = {m, 13'd0};
        end
        return {h[15], se, sm};
    endfunction

endpackage

/* rtl/core/packed_csr_row_decompressor.sv */
// packed csr group to dense fp32 write sequencer
//
// channel | dir | fields
// s_axis  | in  | tdata: vals, gaps, valid_count, row ; tuser: row_start
// m_axis  | out | tdata: address, value_f32, column ; tuser: column_error ; tlast: last
// cfg     | in  | cfg_we, cfg_index, cfg_data
//
// a group is accepted in idle, then passes the load state and the run state, which
// emits one word per valid element; an empty group is accepted without leaving idle.
// the single column adder / stride compare steps once per output word.
// row*row_stride is formed once per group in the load cycle.
// reset clears the running column to minus one and the stride to one.
// a stalled output word holds the sequencer; s_axis_tready is low while busy.
`timescale 1ns / 1ps
module packed_csr_row_decompressor
    import pcsr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vals_0_3, vals_4_7, vals_8_11, vals_12_15, gaps_low_word, gaps_high_word,
    // valid_count, row, zero fill
    input  logic [343:0] s_axis_tdata,
    // row_start
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // address, value_f32, column, zero fill
    output logic [71:0]  m_axis_tdata,
    // column_error
    output logic [0:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [19:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [12:0]      stride_reg;
    logic [19:0]      offset_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [255:0]     vals_reg;
    logic [63:0]      gaps_reg;
    logic [4:0]       count_reg;
    logic [11:0]      row_reg;
    logic [3:0]       idx_reg;
    logic [ADDR_W-1:0] base_reg;
    logic             ovalid_reg;
    logic [71:0]      odata_reg;
    logic             oerr_reg, olast_reg;

    logic [4:0]  cnt_in;
    logic [3:0]  gap;
    logic [14:0] sum;
    logic        err;
    logic        out_free;
    logic [ADDR_W-1:0] addr;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free = !ovalid_reg || m_axis_tready;
    assign cnt_in = (s_axis_tdata[324:320] > 5'd16) ? 5'd16 : s_axis_tdata[324:320];

    assign gap = gaps_reg[idx_reg*GAP_BITS +: GAP_BITS];
    assign sum = {col_reg[COL_W-1], col_reg} + {11'd0, gap} + 15'd1;
    always_comb
    begin
        if (!sum[14] && sum[13:0] > COL_SAT)
            col_next = COL_SAT;
        else
            col_next = sum[13:0];
    end
    assign err  = {6'd0, col_next} >= {7'd0, stride_reg} || col_next[COL_W-1];
    assign addr = base_reg + {11'd0, col_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            stride_reg <= 13'd1;
            offset_reg <= 20'd0;
            col_reg    <= '1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_ROW_STRIDE)
                    stride_reg <= cfg_data[12:0];
                else
                    offset_reg <= cfg_data;
            end
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            if (s_axis_tvalid && s_axis_tready && s_axis_tuser[0])
                col_reg <= '1;
            if (state_reg == ST_RUN && out_free)
            begin
                col_reg    <= col_next;
                ovalid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            vals_reg  <= s_axis_tdata[255:0];
            gaps_reg  <= s_axis_tdata[319:256];
            count_reg <= cnt_in;
            row_reg   <= s_axis_tdata[336:325];
            idx_reg   <= 4'd0;
        end
        if (state_reg == ST_LOAD)
            base_reg <= ADDR_W'({5'd0, offset_reg}
                                + {13'd0, row_reg} * {12'd0, stride_reg});
        if (state_reg == ST_RUN && out_free)
        begin
            odata_reg <= {3'd0, err ? 12'd0 : col_next[11:0],
                          half_to_single(vals_reg[idx_reg*16 +: 16]),
                          err ? {ADDR_W{1'b0}} : addr};
            oerr_reg  <= err;
            olast_reg <= ({1'b0, idx_reg} + 5'd1 == count_reg);
            idx_reg   <= idx_reg + 4'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_axis_tvalid)
                    state_next = (cnt_in == 5'd0) ? ST_IDLE : ST_LOAD;
            ST_LOAD:
                state_next = ST_RUN;
            ST_RUN:
                if (out_free && ({1'b0, idx_reg} + 5'd1 == count_reg))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tuser  = oerr_reg;
    assign m_axis_tlast  = olast_reg;

endmodule
